@@ rtl/iprm_pkg.sv @@
package iprm_pkg;

  localparam int MAX_PACKET_BYTES_DEF = 1024;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam int PROBE_W    = 16;

  localparam logic REG_IDENTIFIER = 1'b0;
  localparam logic REG_SEQUENCE   = 1'b1;

  localparam logic [7:0] TYPE_ECHO_REPLY    = 8'd0;
  localparam logic [7:0] TYPE_TIME_EXCEEDED = 8'd11;

  localparam int MIN_IP_HEADER = 20;
  localparam int ICMP_HEADER   = 8;

  localparam logic [1:0] STATUS_NONE = 2'd0;
  localparam logic [1:0] STATUS_HOP  = 2'd1;
  localparam logic [1:0] STATUS_DEST = 2'd2;

  typedef struct packed {
    logic [PROBE_W-1:0] identifier;
    logic [PROBE_W-1:0] sequence_num;
  } probe_cfg_t;

  function automatic logic [7:0] expected_byte(probe_cfg_t cfg, logic [1:0] k);
    logic [7:0] r;
    case (k)
      2'd0:    r = cfg.identifier[15:8];
      2'd1:    r = cfg.identifier[7:0];
      2'd2:    r = cfg.sequence_num[15:8];
      default: r = cfg.sequence_num[7:0];
    endcase
    return r;
  endfunction

  function automatic logic [5:0] ihl_bytes(logic [7:0] b);
    return {b[3:0], 2'b00};
  endfunction

endpackage

@@ rtl/iprm_ifs.sv @@
interface iprm_pkt_if;
  logic       valid;
  logic       ready;
  logic [7:0] packet_byte;
  logic       last_byte;

  modport source (output valid, output packet_byte, output last_byte, input ready);
  modport sink (input valid, input packet_byte, input last_byte, output ready);
endinterface

interface iprm_res_if;
  logic        valid;
  logic        ready;
  logic [1:0]  reply_status;
  logic [31:0] hop_address;

  modport source (output valid, output reply_status, output hop_address, input ready);
  modport sink (input valid, input reply_status, input hop_address, output ready);
endinterface

@@ rtl/iprm_cfg_regs.sv @@
module iprm_cfg_regs (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [iprm_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [iprm_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [iprm_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                             pready,
  output iprm_pkg::probe_cfg_t             cfg
);
  import iprm_pkg::*;

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr_en) begin
      unique case (paddr[2])
        REG_IDENTIFIER: cfg.identifier   <= pwdata[PROBE_W-1:0];
        REG_SEQUENCE:   cfg.sequence_num <= pwdata[PROBE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_IDENTIFIER: prdata = {{(CFG_DATA_W-PROBE_W){1'b0}}, cfg.identifier};
      REG_SEQUENCE:   prdata = {{(CFG_DATA_W-PROBE_W){1'b0}}, cfg.sequence_num};
      default:        prdata = '0;
    endcase
  end

endmodule

@@ rtl/iprm_match.sv @@
module iprm_match #(
  parameter int MAX_PACKET_BYTES = iprm_pkg::MAX_PACKET_BYTES_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 take,
  input  logic [7:0]           packet_byte,
  input  logic                 last_byte,
  input  iprm_pkg::probe_cfg_t cfg,
  output logic [1:0]           reply_status,
  output logic [31:0]          hop_address
);
  import iprm_pkg::*;

  localparam int POS_W = $clog2(MAX_PACKET_BYTES + 1);
  localparam int CMP_W = (POS_W > 8) ? POS_W + 1 : 9;

  logic [POS_W-1:0] byte_position;
  logic [5:0]       outer_header_bytes;
  logic [7:0]       message_type;
  logic [31:0]      source_address;
  logic [5:0]       inner_header_bytes;
  logic             probe_mismatch;

  logic [POS_W-1:0] byte_position_next;
  logic [5:0]       outer_header_bytes_next;
  logic [7:0]       message_type_next;
  logic [31:0]      source_address_next;
  logic [5:0]       inner_header_bytes_next;
  logic             probe_mismatch_next;

  logic             room;
  logic             in_body;
  logic [POS_W-1:0] off;
  logic [POS_W-1:0] quote_base;
  logic [POS_W-1:0] rel;
  logic             echo_bad;
  logic             quote_bad;
  logic [CMP_W-1:0] len_c;
  logic [CMP_W-1:0] need_c;
  logic [CMP_W-1:0] need_te_c;

  always_comb begin
    room = byte_position < POS_W'(MAX_PACKET_BYTES);

    outer_header_bytes_next = (byte_position == '0) ? ihl_bytes(packet_byte)
                                                    : outer_header_bytes;
    source_address_next = (byte_position >= POS_W'(12) && byte_position <= POS_W'(15))
                          ? {source_address[23:0], packet_byte} : source_address;
    in_body = byte_position >= POS_W'(outer_header_bytes_next);
    off     = byte_position - POS_W'(outer_header_bytes_next);

    message_type_next = (in_body && off == '0) ? packet_byte : message_type;

    echo_bad = in_body && message_type_next == TYPE_ECHO_REPLY
               && off >= POS_W'(4) && off <= POS_W'(7)
               && packet_byte != expected_byte(cfg, off[1:0]);

    inner_header_bytes_next = (in_body && message_type_next == TYPE_TIME_EXCEEDED
                               && off == POS_W'(ICMP_HEADER))
                              ? ihl_bytes(packet_byte) : inner_header_bytes;
    quote_base = POS_W'(ICMP_HEADER) + POS_W'(inner_header_bytes_next);
    rel        = off - quote_base;
    quote_bad  = in_body && message_type_next == TYPE_TIME_EXCEEDED
                 && off >= quote_base && rel >= POS_W'(4) && rel <= POS_W'(7)
                 && packet_byte != expected_byte(cfg, rel[1:0]);

    probe_mismatch_next = probe_mismatch || echo_bad || quote_bad;
    byte_position_next  = byte_position + POS_W'(1);

    if (!room) begin
      outer_header_bytes_next = outer_header_bytes;
      source_address_next     = source_address;
      message_type_next       = message_type;
      inner_header_bytes_next = inner_header_bytes;
      probe_mismatch_next     = probe_mismatch;
      byte_position_next      = byte_position;
    end

    len_c     = CMP_W'(byte_position_next);
    need_c    = CMP_W'(outer_header_bytes_next) + CMP_W'(ICMP_HEADER);
    need_te_c = need_c + CMP_W'(inner_header_bytes_next) + CMP_W'(ICMP_HEADER);

    reply_status = STATUS_NONE;
    if (len_c >= CMP_W'(MIN_IP_HEADER) && len_c >= need_c && !probe_mismatch_next) begin
      if (message_type_next == TYPE_TIME_EXCEEDED) begin
        if (len_c >= need_te_c) begin
          reply_status = STATUS_HOP;
        end
      end else if (message_type_next == TYPE_ECHO_REPLY) begin
        reply_status = STATUS_DEST;
      end
    end
    hop_address = (reply_status != STATUS_NONE) ? source_address_next : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position      <= '0;
      outer_header_bytes <= '0;
      message_type       <= '0;
      source_address     <= '0;
      inner_header_bytes <= '0;
      probe_mismatch     <= 1'b0;
    end else if (take) begin
      if (last_byte) begin
        byte_position      <= '0;
        outer_header_bytes <= '0;
        message_type       <= '0;
        source_address     <= '0;
        inner_header_bytes <= '0;
        probe_mismatch     <= 1'b0;
      end else begin
        byte_position      <= byte_position_next;
        outer_header_bytes <= outer_header_bytes_next;
        message_type       <= message_type_next;
        source_address     <= source_address_next;
        inner_header_bytes <= inner_header_bytes_next;
        probe_mismatch     <= probe_mismatch_next;
      end
    end
  end

endmodule

@@ rtl/icmp_probe_reply_matcher.sv @@
// Matches received IPv4 packets against the current echo probe. Packet bytes
// enter one beat per cycle on pkt (last_byte marks the final byte) and a new
// beat can be taken every cycle; a final beat waits in the input register only
// while an earlier result beat is still unread on res. Each byte passes an
// input register, then compare-and-capture logic into the result register,
// so the verdict for a packet reaches res from the result register once its
// final beat leaves the input register; only the final beat yields
// a result beat. reply_status is 0 for no matching reply, 1 for a time-exceeded
// message quoting the probe, 2 for a matching echo reply; hop_address is the
// outer source address and reads 0 when status is 0. Bytes beyond
// MAX_PACKET_BYTES are dropped from parsing. Write the probe identifier at
// address 0 and sequence at address 4 while no packet is in flight.
module icmp_probe_reply_matcher #(
  parameter int MAX_PACKET_BYTES = iprm_pkg::MAX_PACKET_BYTES_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  iprm_pkt_if.sink                        pkt,
  iprm_res_if.source                      res,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [iprm_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [iprm_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [iprm_pkg::CFG_DATA_W-1:0] prdata,
  output logic                            pready
);
  import iprm_pkg::*;

  probe_cfg_t  cfg;

  logic        s1_valid;
  logic [7:0]  s1_byte;
  logic        s1_last;
  logic        s1_go;

  logic        out_valid;
  logic [1:0]  out_status;
  logic [31:0] out_hop;

  logic [1:0]  match_status;
  logic [31:0] match_hop;

  iprm_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  iprm_match #(
    .MAX_PACKET_BYTES (MAX_PACKET_BYTES)
  ) u_match (
    .clk          (clk),
    .rst          (rst),
    .take         (s1_go),
    .packet_byte  (s1_byte),
    .last_byte    (s1_last),
    .cfg          (cfg),
    .reply_status (match_status),
    .hop_address  (match_hop)
  );

  assign s1_go     = s1_valid && (!s1_last || !out_valid || res.ready);
  assign pkt.ready = !s1_valid || s1_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (pkt.valid && pkt.ready) begin
      s1_valid <= 1'b1;
    end else if (s1_go) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pkt.valid && pkt.ready) begin
      s1_byte <= pkt.packet_byte;
      s1_last <= pkt.last_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_go && s1_last) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_last) begin
      out_status <= match_status;
      out_hop    <= match_hop;
    end
  end

  assign res.valid        = out_valid;
  assign res.reply_status = out_status;
  assign res.hop_address  = out_hop;

`ifndef ASSERT_OFF
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> (res.reply_status == STATUS_NONE || res.reply_status == STATUS_HOP
                   || res.reply_status == STATUS_DEST))
    else $error("reply status out of range");

  a_no_reply_zero_addr: assert property (@(posedge clk) disable iff (rst)
    (res.valid && res.reply_status == STATUS_NONE) |-> res.hop_address == '0)
    else $error("hop address not cleared on no reply");

  a_result_from_last: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(s1_valid && s1_last))
    else $error("result beat without a final packet byte");

  a_stage_flow: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_go) |=> (s1_valid && $stable(s1_byte) && $stable(s1_last)))
    else $error("input register lost a held byte");
`endif

endmodule
